// ----- rtl/dhglcd_pkg.sv -----
// Shared types and constants of the dual half graphic LCD controller.
`timescale 1ns / 1ps
`default_nettype none

package dhglcd_pkg;

  // default geometry
  localparam int PageCountDef      = 8;
  localparam int ColumnsPerHalfDef = 64;

  // bus field widths
  localparam int DataW  = 8;
  localparam int TicksW = 16;

  // configuration register indexes
  localparam logic CFG_WRITE_BUSY = 1'b0;
  localparam logic CFG_READ_BUSY  = 1'b1;

  // reset values of the busy tick registers
  localparam logic [TicksW-1:0] WriteBusyReset = 16'd200;
  localparam logic [TicksW-1:0] ReadBusyReset  = 16'd500;

  // status byte bits
  localparam int StatusBusyBit = 7;
  localparam int StatusOnBit   = 5;

  // instruction class, from bus_data[7:6]
  typedef enum logic [1:0] {
    INSTR_DISPLAY = 2'b00,
    INSTR_COLUMN  = 2'b01,
    INSTR_PAGE    = 2'b10,
    INSTR_START   = 2'b11
  } instr_e;

endpackage

`default_nettype wire

// ----- rtl/dual_half_glcd_controller.sv -----
// Top level of the dual half graphic LCD controller: bus decode, half state and display RAM.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// - Input channel (in_valid_i / in_stall_o) carries one item per bus event:
//   mode_i = 1 is a one microsecond tick, mode_i = 0 is a bus access to the
//   half chosen by half_select_i (1 left, 0 right) with register_select_i,
//   read_not_write_i and bus_data_i.
// - Output channel (out_valid_o / out_stall_i) returns exactly one item per
//   input item: read_data_o, read_valid_o, display_written_o.
// - Config port: cfg_we_i writes cfg_data_i into write_busy_ticks (index 0)
//   or read_busy_ticks (index 1); the user must write only while the block is idle (not enforced by the block).
// - Results are registered: an item accepted at one edge is shown in the cycle after.
//   Throughput is one item per cycle while in_stall_o is low, set by the single display RAM port
//   that is read or written at the accepting edge.
// - After reset the display RAM is cleared one byte a cycle, all
//   PAGE_COUNT * 2 * COLUMNS_PER_HALF bytes (1024 by default); in_stall_o
//   stays high for that pass. Config writes are taken meanwhile.
// - The output register holds one item; while it is full and out_stall_i is
//   high the item holds and in_stall_o is raised. A freeing slot takes the
//   next item in the same cycle.

module dual_half_glcd_controller #(
  parameter int PAGE_COUNT       = dhglcd_pkg::PageCountDef,
  parameter int COLUMNS_PER_HALF = dhglcd_pkg::ColumnsPerHalfDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input items
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire logic                          mode_i,
  input  wire logic                          half_select_i,
  input  wire logic                          register_select_i,
  input  wire logic                          read_not_write_i,
  input  wire logic [dhglcd_pkg::DataW-1:0]  bus_data_i,
  // result items
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic [dhglcd_pkg::DataW-1:0]  read_data_o,
  output      logic                          read_valid_o,
  output      logic                          display_written_o,
  // configuration writes
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_index_i,
  input  wire logic [dhglcd_pkg::TicksW-1:0] cfg_data_i
);

  localparam int DataW   = dhglcd_pkg::DataW;
  localparam int TicksW  = dhglcd_pkg::TicksW;
  localparam int RowLen  = 2 * COLUMNS_PER_HALF;
  localparam int Depth   = PAGE_COUNT * RowLen;
  localparam int AddrW   = $clog2(Depth);
  localparam int ColW    = (COLUMNS_PER_HALF > 1) ? $clog2(COLUMNS_PER_HALF) : 1;
  localparam int PageW   = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int ColCodes  = 64;  // bus_data[5:0]
  localparam int PageCodes = 8;   // bus_data[2:0]

  // ------------------------------------------------------------------
  // Address reduction tables: bus field modulo the half's geometry.
  // ------------------------------------------------------------------
  logic [ColW-1:0]  col_mod_tbl  [ColCodes];
  logic [PageW-1:0] page_mod_tbl [PageCodes];

  for (genvar v = 0; v < ColCodes; v++) begin : g_col_tbl
    assign col_mod_tbl[v] = ColW'(v % COLUMNS_PER_HALF);
  end
  for (genvar v = 0; v < PageCodes; v++) begin : g_page_tbl
    assign page_mod_tbl[v] = PageW'(v % PAGE_COUNT);
  end

  // ------------------------------------------------------------------
  // Registers
  // ------------------------------------------------------------------
  logic [TicksW-1:0] wticks_q, rticks_q;

  logic [ColW-1:0]   col_q   [2];
  logic [ColW-1:0]   col_d   [2];
  logic [PageW-1:0]  page_q  [2];
  logic [PageW-1:0]  page_d  [2];
  logic [1:0]        on_q, on_d;
  logic [1:0]        dummy_q, dummy_d;
  logic [TicksW-1:0] busy_q  [2];
  logic [TicksW-1:0] busy_d  [2];

  logic              clear_q;
  logic [AddrW-1:0]  clr_addr_q;

  logic              out_valid_q;
  logic              rvalid_q, rvalid_d;
  logic              written_q, written_d;
  logic              sel_mem_q, sel_mem_d;
  logic [DataW-1:0]  status_q, status_d;
  logic [DataW-1:0]  mem_rdata_q;

  logic [DataW-1:0]  mem_q [Depth];

  // ------------------------------------------------------------------
  // Handshake
  // ------------------------------------------------------------------
  logic accept;
  assign in_stall_o = clear_q | (out_valid_q & out_stall_i);
  assign accept     = in_valid_i & ~in_stall_o;

  // ------------------------------------------------------------------
  // Decode
  // ------------------------------------------------------------------
  logic               hsel;        // 0 left, 1 right
  logic               is_access;
  logic               is_write;
  logic               is_data_wr;
  logic               is_data_rd;
  logic               is_dummy;
  dhglcd_pkg::instr_e instr;
  logic [AddrW-1:0]   addr;
  logic [ColW:0]      col_inc;
  logic [ColW-1:0]    col_next;

  assign hsel      = ~half_select_i;
  assign is_access = ~mode_i;
  assign is_write  = is_access & ~read_not_write_i;
  assign instr     = dhglcd_pkg::instr_e'(bus_data_i[7:6]);

  assign is_data_wr = is_write & register_select_i;
  assign is_dummy   = is_access & read_not_write_i & register_select_i & dummy_q[hsel];
  assign is_data_rd = is_access & read_not_write_i & register_select_i & ~dummy_q[hsel];

  // display RAM cell of the addressed half
  assign addr = AddrW'(page_q[hsel]) * AddrW'(RowLen)
              + AddrW'(hsel) * AddrW'(COLUMNS_PER_HALF)
              + AddrW'(col_q[hsel]);

  // column advance wraps within the half
  assign col_inc  = {1'b0, col_q[hsel]} + (ColW + 1)'(1);
  assign col_next = (col_inc >= (ColW + 1)'(COLUMNS_PER_HALF)) ? '0 : col_inc[ColW-1:0];

  // ------------------------------------------------------------------
  // Next state of both halves
  // ------------------------------------------------------------------
  always_comb begin
    for (int h = 0; h < 2; h++) begin
      col_d[h]  = col_q[h];
      page_d[h] = page_q[h];
      busy_d[h] = busy_q[h];
    end
    on_d    = on_q;
    dummy_d = dummy_q;

    if (mode_i) begin
      for (int h = 0; h < 2; h++) begin
        if (busy_q[h] != '0) begin
          busy_d[h] = busy_q[h] - TicksW'(1);
        end
      end
    end else if (is_write) begin
      dummy_d[hsel] = 1'b1;
      busy_d[hsel]  = wticks_q;
      if (register_select_i) begin
        col_d[hsel] = col_next;
      end else begin
        case (instr)
          dhglcd_pkg::INSTR_COLUMN: col_d[hsel]  = col_mod_tbl[bus_data_i[5:0]];
          dhglcd_pkg::INSTR_PAGE:   page_d[hsel] = page_mod_tbl[bus_data_i[2:0]];
          dhglcd_pkg::INSTR_DISPLAY: on_d[hsel]  = bus_data_i[0];
          default: ;  // start line: no effect beyond busy and dummy
        endcase
      end
    end else begin
      busy_d[hsel] = rticks_q;
      if (is_dummy) begin
        dummy_d[hsel] = 1'b0;
      end else if (is_data_rd) begin
        col_d[hsel] = col_next;
      end
    end
  end

  // ------------------------------------------------------------------
  // Result of the item
  // ------------------------------------------------------------------
  always_comb begin
    status_d  = '0;
    sel_mem_d = 1'b0;
    rvalid_d  = 1'b0;
    written_d = is_data_wr;
    if (is_access & read_not_write_i) begin
      if (!register_select_i) begin
        status_d[dhglcd_pkg::StatusBusyBit] = (busy_q[hsel] != '0);
        status_d[dhglcd_pkg::StatusOnBit]   = on_q[hsel];
        rvalid_d = 1'b1;
      end else if (is_data_rd) begin
        sel_mem_d = 1'b1;
        rvalid_d  = 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------
  // Control and state registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wticks_q <= dhglcd_pkg::WriteBusyReset;
      rticks_q <= dhglcd_pkg::ReadBusyReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        dhglcd_pkg::CFG_WRITE_BUSY: wticks_q <= cfg_data_i;
        dhglcd_pkg::CFG_READ_BUSY:  rticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int h = 0; h < 2; h++) begin
        col_q[h]  <= '0;
        page_q[h] <= '0;
        busy_q[h] <= '0;
      end
      on_q    <= '0;
      dummy_q <= '0;
    end else if (accept) begin
      for (int h = 0; h < 2; h++) begin
        col_q[h]  <= col_d[h];
        page_q[h] <= page_d[h];
        busy_q[h] <= busy_d[h];
      end
      on_q    <= on_d;
      dummy_q <= dummy_d;
    end
  end

  // clearing pass over the display RAM after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q    <= 1'b1;
      clr_addr_q <= '0;
    end else if (clear_q) begin
      clr_addr_q <= clr_addr_q + AddrW'(1);
      if (clr_addr_q == AddrW'(Depth - 1)) begin
        clear_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rvalid_q  <= rvalid_d;
      written_q <= written_d;
      sel_mem_q <= sel_mem_d;
      status_q  <= status_d;
    end
  end

  // ------------------------------------------------------------------
  // Display RAM: one port, read data registered
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (clear_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (accept && is_data_wr) begin
      mem_q[addr] <= bus_data_i;
    end
    if (accept) begin
      mem_rdata_q <= mem_q[addr];
    end
  end

  // ------------------------------------------------------------------
  // Outputs
  // ------------------------------------------------------------------
  assign out_valid_o       = out_valid_q;
  assign read_data_o       = sel_mem_q ? mem_rdata_q : status_q;
  assign read_valid_o      = rvalid_q;
  assign display_written_o = written_q;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  a_stall_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_q |-> in_stall_o)
    else $error("item taken during RAM clearing pass");

  a_tick_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode_i) |=>
      (out_valid_o && !read_valid_o && !display_written_o && read_data_o == '0))
    else $error("tick item gave a nonzero result");

  a_excl_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(read_valid_o && display_written_o))
    else $error("result flags both read and write");

  a_wr_busy_left : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_write && half_select_i) |=> (busy_q[0] == $past(wticks_q)))
    else $error("left half busy count not reloaded on write");

endmodule

`default_nettype wire

// ----- tb/tb_dual_half_glcd_controller.sv -----
// Self-checking testbench of the dual half graphic LCD controller.
`timescale 1ns / 1ps

module tb_dual_half_glcd_controller;

  localparam int   MemDepth   = dhglcd_pkg::PageCountDef * 2 * dhglcd_pkg::ColumnsPerHalfDef;
  localparam int   ColsHalf   = dhglcd_pkg::ColumnsPerHalfDef;
  localparam int   IdlePct    = 35;   // percent of cycles each side sits out
  localparam int   HoldCycles = 80;   // long receiver hold-off
  localparam int   ShowLimit  = 10;   // failures printed in full

  // bus field codes
  localparam logic MODE_ACCESS = 1'b0;
  localparam logic MODE_TICK   = 1'b1;
  localparam logic HALF_LEFT   = 1'b1;
  localparam logic HALF_RIGHT  = 1'b0;
  localparam logic RS_INSTR    = 1'b0;
  localparam logic RS_DATA     = 1'b1;
  localparam logic RNW_WRITE   = 1'b0;
  localparam logic RNW_READ    = 1'b1;

  // one bus event as it goes into the block
  typedef struct packed {
    logic                         mode;
    logic                         half;
    logic                         rs;
    logic                         rnw;
    logic [dhglcd_pkg::DataW-1:0] data;
  } bus_item_t;

  // what the block returns for one bus event
  typedef struct packed {
    logic [dhglcd_pkg::DataW-1:0] rdata;
    logic                         rvalid;
    logic                         written;
  } bus_result_t;

  // ---------------------------------------------------------------------------
  // DUT signals; every input has a known value from time zero
  // ---------------------------------------------------------------------------
  logic                          clk_i             = 1'b0;
  logic                          rst_ni            = 1'b0;
  logic                          in_valid_i        = 1'b0;
  logic                          mode_i            = MODE_TICK;
  logic                          half_select_i     = HALF_LEFT;
  logic                          register_select_i = RS_INSTR;
  logic                          read_not_write_i  = RNW_WRITE;
  logic [dhglcd_pkg::DataW-1:0]  bus_data_i        = '0;
  logic                          out_stall_i       = 1'b0;
  logic                          cfg_we_i          = 1'b0;
  logic                          cfg_index_i       = dhglcd_pkg::CFG_WRITE_BUSY;
  logic [dhglcd_pkg::TicksW-1:0] cfg_data_i        = '0;

  logic                          in_stall_o;
  logic                          out_valid_o;
  logic [dhglcd_pkg::DataW-1:0]  read_data_o;
  logic                          read_valid_o;
  logic                          display_written_o;

  dual_half_glcd_controller u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .mode_i            (mode_i),
    .half_select_i     (half_select_i),
    .register_select_i (register_select_i),
    .read_not_write_i  (read_not_write_i),
    .bus_data_i        (bus_data_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .read_data_o       (read_data_o),
    .read_valid_o      (read_valid_o),
    .display_written_o (display_written_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  initial forever #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow copy of the controller: display RAM, per-half address and flags,
  // busy counters and the two busy-tick registers.
  // Half index: 0 is the left half (select high), 1 the right half.
  // ---------------------------------------------------------------------------
  logic [dhglcd_pkg::DataW-1:0]  shadow_ram [MemDepth];
  int                            col_addr   [2];
  int                            page_addr  [2];
  logic                          lcd_on     [2];
  logic                          dummy_due  [2];
  logic [dhglcd_pkg::TicksW-1:0] busy_left  [2];
  logic [dhglcd_pkg::TicksW-1:0] write_ticks = dhglcd_pkg::WriteBusyReset;
  logic [dhglcd_pkg::TicksW-1:0] read_ticks  = dhglcd_pkg::ReadBusyReset;

  bus_item_t   access_q [$];   // bus events waiting to be driven
  bus_result_t lcd_result_q [$];   // responses owed by the block

  logic in_taken  = 1'b0;
  logic tx_steady = 1'b0;
  logic rx_steady = 1'b0;
  int   hold_req  = 0;
  int   hold_ack  = 0;
  int   hold_left = 0;

  int queued_cnt   = 0;
  int accepted_cnt = 0;
  int fail_cnt     = 0;
  int reads_cnt    = 0;
  int writes_cnt   = 0;
  int setting_cnt  = 1;   // reset values count as the first setting

  // Response of the controller to one bus event; advances the shadow state.
  function automatic bus_result_t lcd_bus_response(bus_item_t ev);
    bus_result_t r = '0;
    int h = ev.half ? 0 : 1;
    int byte_idx = page_addr[h] * 2 * ColsHalf + h * ColsHalf + col_addr[h];
    if (ev.mode == MODE_TICK) begin
      // tick: both busy counters run down, nothing on the bus
      for (int k = 0; k < 2; k++) begin
        if (busy_left[k] != 0) busy_left[k] = busy_left[k] - 1'b1;
      end
    end else if (ev.rnw == RNW_WRITE) begin
      dummy_due[h] = 1'b1;   // any write arms the dummy read
      if (ev.rs == RS_DATA) begin
        shadow_ram[byte_idx] = ev.data;
        col_addr[h] = (col_addr[h] + 1) % ColsHalf;
        r.written = 1'b1;
      end else begin
        case (dhglcd_pkg::instr_e'(ev.data[7:6]))
          dhglcd_pkg::INSTR_COLUMN:  col_addr[h]  = int'(ev.data[5:0]) % ColsHalf;
          dhglcd_pkg::INSTR_PAGE:
            page_addr[h] = int'(ev.data[2:0]) % dhglcd_pkg::PageCountDef;
          dhglcd_pkg::INSTR_DISPLAY: lcd_on[h]    = ev.data[0];
          default: ;   // start line: no effect beyond busy and dummy
        endcase
      end
      busy_left[h] = write_ticks;
    end else begin
      if (ev.rs == RS_DATA) begin
        if (dummy_due[h]) begin
          dummy_due[h] = 1'b0;   // dummy read: nothing driven, column stays
        end else begin
          r.rdata  = shadow_ram[byte_idx];
          r.rvalid = 1'b1;
          col_addr[h] = (col_addr[h] + 1) % ColsHalf;
        end
      end else begin
        // status: busy seen before this access reloads the counter
        r.rdata[dhglcd_pkg::StatusBusyBit] = (busy_left[h] != 0);
        r.rdata[dhglcd_pkg::StatusOnBit]   = lcd_on[h];
        r.rvalid = 1'b1;
      end
      busy_left[h] = read_ticks;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: an item is taken at a rising edge with valid high, stall low.
  // The shadow model advances here, so it always sees the register values
  // in force when the block took the item.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : take_side
    bus_item_t ev;
    in_taken <= in_valid_i && !in_stall_o;
    if (in_valid_i && !in_stall_o) begin
      ev = {mode_i, half_select_i, register_select_i, read_not_write_i, bus_data_i};
      lcd_result_q.push_back(lcd_bus_response(ev));
      accepted_cnt++;
    end
  end

  // Driver: moves on only after the current item was taken; payload holds
  // while stalled, and the idle decision never looks at stall.
  always @(negedge clk_i) begin : send_side
    bus_item_t nxt;
    if (!in_valid_i || in_taken) begin
      if (access_q.size() != 0 && (tx_steady || $urandom_range(99) >= IdlePct)) begin
        nxt = access_q.pop_front();
        in_valid_i        <= 1'b1;
        mode_i            <= nxt.mode;
        half_select_i     <= nxt.half;
        register_select_i <= nxt.rs;
        read_not_write_i  <= nxt.rnw;
        bus_data_i        <= nxt.data;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, none when steady, and a long hold-off on request
  // so the output register fills and the block backs up its input.
  always @(negedge clk_i) begin : recv_side
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_ack != hold_req) begin
      hold_ack    <= hold_req;
      hold_left   <= HoldCycles;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !rx_steady && ($urandom_range(99) < IdlePct);
    end
  end

  // Result checker: oldest expectation against every result taken.
  always @(posedge clk_i) begin : result_side
    bus_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (lcd_result_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= ShowLimit)
          $display("%0t: result with nothing outstanding: data %h rv %b wr %b",
                   $realtime, read_data_o, read_valid_o, display_written_o);
      end else begin
        want = lcd_result_q.pop_front();
        if (read_data_o !== want.rdata || read_valid_o !== want.rvalid ||
            display_written_o !== want.written) begin
          fail_cnt++;
          if (fail_cnt <= ShowLimit)
            $display("%0t: mismatch: data %h/%h rv %b/%b wr %b/%b (expected/actual)",
                     $realtime, want.rdata, read_data_o, want.rvalid, read_valid_o,
                     want.written, display_written_o);
        end
        if (want.rvalid) reads_cnt++;
        if (want.written) writes_cnt++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_item(logic mode, logic half, logic rs, logic rnw,
                           logic [dhglcd_pkg::DataW-1:0] data);
    bus_item_t ev;
    ev.mode = mode;
    ev.half = half;
    ev.rs   = rs;
    ev.rnw  = rnw;
    ev.data = data;
    access_q.push_back(ev);
    queued_cnt++;
  endtask

  // tick; the other fields are don't-care and get random values
  task automatic push_tick();
    push_item(MODE_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)),
              1'($urandom_range(1)), 8'($urandom_range(255)));
  endtask

  task automatic push_instr(logic half, dhglcd_pkg::instr_e cls, logic [5:0] arg);
    push_item(MODE_ACCESS, half, RS_INSTR, RNW_WRITE, {cls, arg});
  endtask

  task automatic push_write(logic half, logic [dhglcd_pkg::DataW-1:0] data);
    push_item(MODE_ACCESS, half, RS_DATA, RNW_WRITE, data);
  endtask

  // bus_data is ignored on reads, so it carries noise
  task automatic push_read(logic half);
    push_item(MODE_ACCESS, half, RS_DATA, RNW_READ, 8'($urandom_range(255)));
  endtask

  task automatic push_status(logic half);
    push_item(MODE_ACCESS, half, RS_INSTR, RNW_READ, 8'($urandom_range(255)));
  endtask

  // Typical driver software: address a run, write it, re-address, dummy read,
  // read it back. Columns near the end exercise the wrap.
  task automatic push_page_run();
    logic       half = 1'($urandom_range(1));
    int         n    = $urandom_range(1, 8);
    logic [5:0] col  = ($urandom_range(3) == 0) ?
                       6'(ColsHalf - 1 - $urandom_range(3)) : 6'($urandom_range(63));
    push_instr(half, dhglcd_pkg::INSTR_PAGE, 6'($urandom_range(63)));
    push_instr(half, dhglcd_pkg::INSTR_COLUMN, col);
    repeat (n) begin
      if ($urandom_range(4) == 0) push_tick();
      push_write(half, 8'($urandom_range(255)));
    end
    push_instr(half, dhglcd_pkg::INSTR_COLUMN, col);
    push_read(half);
    repeat (n) begin
      if ($urandom_range(5) == 0) push_status(half);
      push_read(half);
    end
  endtask

  // Mostly well-formed runs, with tick bursts and fully random accesses.
  task automatic fill_random(int target);
    int first = queued_cnt;
    while (queued_cnt - first < target) begin
      if ($urandom_range(99) < 60) begin
        push_page_run();
      end else if ($urandom_range(2) == 0) begin
        repeat ($urandom_range(1, 6)) push_tick();
      end else begin
        push_item(MODE_ACCESS, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 8'($urandom_range(255)));
      end
    end
  endtask

  // Sender pauses here until every owed response has come back.
  task automatic wait_drained();
    while (access_q.size() != 0 || in_valid_i || lcd_result_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_ticks_reg(logic idx, logic [dhglcd_pkg::TicksW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == dhglcd_pkg::CFG_WRITE_BUSY) write_ticks = val;
    else read_ticks = val;
  endtask

  // One phase: block idle, new busy-tick setting, then a random batch.
  // squeeze keeps the sender busy while the receiver holds off.
  task automatic run_phase(logic [dhglcd_pkg::TicksW-1:0] wt,
                           logic [dhglcd_pkg::TicksW-1:0] rt, int target,
                           logic steady, logic squeeze);
    wait_drained();
    write_ticks_reg(dhglcd_pkg::CFG_WRITE_BUSY, wt);
    write_ticks_reg(dhglcd_pkg::CFG_READ_BUSY, rt);
    setting_cnt++;
    tx_steady = steady || squeeze;
    rx_steady = steady;
    if (squeeze) hold_req++;
    fill_random(target);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    foreach (shadow_ram[i]) shadow_ram[i] = '0;
    for (int k = 0; k < 2; k++) begin
      col_addr[k]  = 0;
      page_addr[k] = 0;
      lcd_on[k]    = 1'b0;
      dummy_due[k] = 1'b0;
      busy_left[k] = '0;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the reset busy-tick values. The block clears its RAM
    // first and stalls meanwhile; the driver simply waits on the handshake.
    push_status(HALF_LEFT);                                      // idle, off
    push_status(HALF_RIGHT);
    push_instr(HALF_LEFT, dhglcd_pkg::INSTR_DISPLAY, 6'h3F);     // on
    push_status(HALF_LEFT);                                      // busy and on
    push_instr(HALF_RIGHT, dhglcd_pkg::INSTR_DISPLAY, 6'h3E);    // off, bit 0 clear
    push_tick();
    push_instr(HALF_LEFT, dhglcd_pkg::INSTR_PAGE, 6'h3F);        // page 7
    push_instr(HALF_LEFT, dhglcd_pkg::INSTR_COLUMN, 6'h3F);      // last column
    push_instr(HALF_LEFT, dhglcd_pkg::INSTR_START, 6'h3F);       // start line, ignored
    push_write(HALF_LEFT, 8'hFF);                                // column wraps to 0
    push_read(HALF_LEFT);                                        // dummy
    push_instr(HALF_LEFT, dhglcd_pkg::INSTR_COLUMN, 6'h3F);
    push_read(HALF_LEFT);                                        // dummy again
    push_read(HALF_LEFT);                                        // FF, wraps
    push_read(HALF_LEFT);                                        // column 0, still zero
    push_instr(HALF_RIGHT, dhglcd_pkg::INSTR_PAGE, 6'h00);
    push_instr(HALF_RIGHT, dhglcd_pkg::INSTR_COLUMN, 6'h00);
    push_write(HALF_RIGHT, 8'h00);
    push_write(HALF_RIGHT, 8'hA5);
    push_instr(HALF_RIGHT, dhglcd_pkg::INSTR_COLUMN, 6'h00);
    push_read(HALF_RIGHT);
    push_read(HALF_RIGHT);
    push_read(HALF_RIGHT);
    push_status(HALF_RIGHT);                                     // busy, off
    push_tick();

    // Random part over several busy-tick settings, extremes included.
    run_phase(16'd0,     16'd0,     200, 1'b0, 1'b0);   // never busy
    run_phase(16'd1,     16'd3,     200, 1'b1, 1'b0);   // no idling either side
    run_phase(16'hFFFF,  16'hFFFF,  150, 1'b0, 1'b1);   // long receiver hold
    run_phase(16'd2,     16'd7,     250, 1'b0, 1'b0);
    run_phase(16'($urandom_range(20)), 16'($urandom_range(20)), 250, 1'b0, 1'b0);
    run_phase(dhglcd_pkg::WriteBusyReset, dhglcd_pkg::ReadBusyReset, 200, 1'b0, 1'b0);
    run_phase(16'($urandom_range(65535)), 16'($urandom_range(65535)), 100, 1'b0, 1'b1);
    wait_drained();
    repeat (10) @(posedge clk_i);

    $display("covered %0d bus items over %0d busy-tick settings", accepted_cnt, setting_cnt);
    $display("%0d reads drove the bus, %0d display writes, %0d failures",
             reads_cnt, writes_cnt, fail_cnt + lcd_result_q.size());
    if (fail_cnt == 0 && lcd_result_q.size() == 0) begin
      $display("tb_dual_half_glcd_controller: clean");
    end else begin
      $display("tb_dual_half_glcd_controller: errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run (clear pass, stalls, holds).
  initial begin
    #5_000_000;
    $display("tb_dual_half_glcd_controller: errors");
    $finish;
  end

endmodule
